// ----- hdl/hssq_pkg.sv -----
// Shared types, codes and the half-step coil table for the stepper sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hssq_pkg;

   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned CSR_DAT_W = 16;
   localparam int unsigned CNT_W     = 16;
   localparam int unsigned COIL_W    = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_REV = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_DELAY    = CSR_IDX_W'(1);

   localparam logic [CNT_W-1:0] STEPS_PER_REV_RESET = CNT_W'(4096);
   localparam logic [CNT_W-1:0] STEP_DELAY_RESET    = '0;
   localparam logic [CNT_W-1:0] TICKS_MAX           = '1;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_MOVE = 1'b1
   } cmd_type;

   localparam logic [COIL_W-1:0] HALF_STEP_TABLE [8] = '{
      4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
   };

   typedef struct packed {
      logic [CNT_W-1:0] steps_per_rev;
      logic [CNT_W-1:0] step_delay_ticks;
   } cfg_type;

   typedef struct packed {
      logic [COIL_W-1:0] coils;
      logic [CNT_W-1:0]  position;
      logic [CNT_W-1:0]  steps_remaining;
      logic              stepped;
      logic              busy_res;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hdl/hssq_csr.sv -----
// Configuration registers of the stepper sequencer: steps per revolution, step delay.
// Depends on hssq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hssq_csr
   import hssq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data,
   output      cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_STEPS_PER_REV: cfg_in.steps_per_rev    = csr_data;
            CSR_STEP_DELAY:    cfg_in.step_delay_ticks = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steps_per_rev    <= STEPS_PER_REV_RESET;
         cfg_ff.step_delay_ticks <= STEP_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hdl/hssq_core.sv -----
// Motion state of the stepper sequencer and its one-pass update per item.
// Depends on hssq_pkg; fed by hssq_csr, drains into hssq_rsp.
`timescale 1ns / 1ps
`default_nettype none

module hssq_core
   import hssq_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    item_fire,
   input  wire logic                    req_cmd,
   input  wire logic signed [CNT_W-1:0] req_move_steps,
   input  wire cfg_type                 cfg,
   output      rsp_type                 rsp_next
);

   logic [CNT_W-1:0]  position_ff, position_in;
   logic              forward_ff, forward_in;
   logic [CNT_W-1:0]  pending_ff, pending_in;
   logic [CNT_W-1:0]  elapsed_ff, elapsed_in;
   logic [COIL_W-1:0] coils_ff, coils_in;

   logic [CNT_W-1:0] elapsed_inc;
   logic [CNT_W:0]   rev;
   logic [CNT_W:0]   pos_plus;
   logic [CNT_W:0]   pos_wide;
   logic [CNT_W:0]   pos_step;
   logic [CNT_W-1:0] raw;
   logic             do_step;

   assign raw         = req_move_steps;
   assign elapsed_inc = (elapsed_ff == TICKS_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
   assign do_step     = (req_cmd == CMD_TICK) && (pending_ff != '0)
                        && (elapsed_inc >= cfg.step_delay_ticks);

   assign rev      = (cfg.steps_per_rev == '0) ? {1'b1, {CNT_W{1'b0}}}
                                               : {1'b0, cfg.steps_per_rev};
   assign pos_wide = {1'b0, position_ff};
   assign pos_plus = pos_wide + 1'b1;

   always_comb begin
      if (forward_ff) begin
         pos_step = (pos_plus >= rev) ? '0 : pos_plus;
      end else if (position_ff == '0 || pos_wide >= rev) begin
         pos_step = rev - 1'b1;
      end else begin
         pos_step = pos_wide - 1'b1;
      end
   end

   always_comb begin
      position_in = position_ff;
      forward_in  = forward_ff;
      pending_in  = pending_ff;
      elapsed_in  = elapsed_ff;
      coils_in    = coils_ff;
      if (req_cmd == CMD_MOVE) begin
         if (raw == '0) begin
            pending_in = '0;
         end else if (raw[CNT_W-1]) begin
            forward_in = 1'b0;
            pending_in = '0 - raw;
         end else begin
            forward_in = 1'b1;
            pending_in = raw;
         end
      end else if (do_step) begin
         elapsed_in  = '0;
         position_in = pos_step[CNT_W-1:0];
         pending_in  = pending_ff - 1'b1;
         coils_in    = HALF_STEP_TABLE[pos_step[2:0]];
      end else begin
         elapsed_in = elapsed_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         forward_ff  <= 1'b0;
         pending_ff  <= '0;
         elapsed_ff  <= '0;
         coils_ff    <= '0;
      end else if (item_fire) begin
         position_ff <= position_in;
         forward_ff  <= forward_in;
         pending_ff  <= pending_in;
         elapsed_ff  <= elapsed_in;
         coils_ff    <= coils_in;
      end
   end

   always_comb begin
      rsp_next.coils           = coils_in;
      rsp_next.position        = position_in;
      rsp_next.steps_remaining = pending_in;
      rsp_next.stepped         = do_step;
      rsp_next.busy_res        = (pending_in != '0);
   end

endmodule

`default_nettype wire

// ----- hdl/hssq_rsp.sv -----
// Result register of the stepper sequencer with its valid/ready handshake.
// Depends on hssq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hssq_rsp
   import hssq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type rsp_next,
   input  wire logic    rsp_ready,
   output      logic    rsp_valid,
   output      logic    can_load,
   output      rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_next;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ----- hdl/half_step_stepper_sequencer.sv -----
// Half-step sequencer for a four-coil unipolar stepper: takes tick and move items and
// returns one result item for each. Every item is handled combinationally against the motion
// state registers; its result is held in an output register and appears in the cycle after
// acceptance. A new item is taken in the same cycle the previous result leaves, so the block
// sustains one item per clock unless the result side stalls. Configuration writes take effect
// in the cycle after acceptance and should only be made while idle.
// Depends on hssq_pkg, hssq_csr, hssq_core and hssq_rsp.
`timescale 1ns / 1ps
`default_nettype none

module half_step_stepper_sequencer
   import hssq_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    csr_valid,
   output      logic                    csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DAT_W-1:0]    csr_data,

   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire logic                    req_cmd,
   input  wire logic signed [CNT_W-1:0] req_move_steps,

   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      logic [COIL_W-1:0]       rsp_coils,
   output      logic [CNT_W-1:0]        rsp_position,
   output      logic [CNT_W-1:0]        rsp_steps_remaining,
   output      logic                    rsp_stepped,
   output      logic                    rsp_busy_res
);

   cfg_type cfg;
   rsp_type rsp_next;
   rsp_type rsp_data;
   logic    item_fire;
   logic    can_load;

   assign req_ready = can_load;
   assign item_fire = req_valid && can_load;

   hssq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hssq_core u_core (
      .clock          (clock),
      .reset          (reset),
      .item_fire      (item_fire),
      .req_cmd        (req_cmd),
      .req_move_steps (req_move_steps),
      .cfg            (cfg),
      .rsp_next       (rsp_next)
   );

   hssq_rsp u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (item_fire),
      .rsp_next  (rsp_next),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .can_load  (can_load),
      .rsp_data  (rsp_data)
   );

   assign rsp_coils           = rsp_data.coils;
   assign rsp_position        = rsp_data.position;
   assign rsp_steps_remaining = rsp_data.steps_remaining;
   assign rsp_stepped         = rsp_data.stepped;
   assign rsp_busy_res        = rsp_data.busy_res;

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      item_fire |=> rsp_valid)
      else $error("accepted item produced no result");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while result stalled");

   a_move_never_steps: assert property (@(posedge clock) disable iff (reset)
      item_fire && req_cmd == CMD_MOVE |=> !rsp_stepped)
      else $error("move item reported a step");

   a_busy_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_busy_res == (rsp_steps_remaining != '0))
      else $error("busy flag disagrees with remaining steps");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for half_step_stepper_sequencer: directed table, random phases, idle-tick run. Results are checked
// against an in-bench model of the half-step motion state or pinned rows' values. Depends on hssq_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
   import hssq_pkg::*;

   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned PHASES     = 10;
   localparam int unsigned PHASE_LEN  = 145;
   localparam int unsigned IDLE_TICKS = 200;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_LAST  = '1;
   localparam logic [COIL_W-1:0] PHASE_COILS [8] = '{
      4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
   };

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_PINNED,
      ROW_CSR
   } row_kind;

   typedef struct packed {
      row_kind              kind;
      cmd_type              cmd;
      logic [CNT_W-1:0]     steps;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DAT_W-1:0] data;
      rsp_type              want;
   } plan_row;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DAT_W-1:0]    csr_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_cmd = CMD_TICK;
   logic signed [CNT_W-1:0] req_move_steps = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [COIL_W-1:0]       rsp_coils;
   logic [CNT_W-1:0]        rsp_position;
   logic [CNT_W-1:0]        rsp_steps_remaining;
   logic                    rsp_stepped;
   logic                    rsp_busy_res;

   // model of the motion state
   logic [CNT_W-1:0]  cfg_rev = STEPS_PER_REV_RESET;
   logic [CNT_W-1:0]  cfg_delay = '0;
   logic [CNT_W-1:0]  track_pos = '0;
   logic              track_fwd = 1'b0;
   logic [CNT_W-1:0]  track_pending = '0;
   logic [CNT_W-1:0]  track_elapsed = '0;
   logic [COIL_W-1:0] track_coils = '0;

   rsp_type     pending_results [$];
   plan_row     plan [$];
   bit          pin_on = 1'b0;
   rsp_type     pin_want = '0;
   bit          calm = 1'b0;
   int unsigned failures = 0;
   int unsigned quiet_cycles = 0;

   half_step_stepper_sequencer dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_move_steps      (req_move_steps),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_coils           (rsp_coils),
      .rsp_position        (rsp_position),
      .rsp_steps_remaining (rsp_steps_remaining),
      .rsp_stepped         (rsp_stepped),
      .rsp_busy_res        (rsp_busy_res)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic rsp_type stepper_next(input logic cmd, input logic [CNT_W-1:0] raw);
      logic [CNT_W:0] rev;
      logic [CNT_W:0] pos;
      logic           moved;
      rsp_type        r;
      moved = 1'b0;
      rev = (cfg_rev == '0) ? {1'b1, {CNT_W{1'b0}}} : {1'b0, cfg_rev};
      pos = {1'b0, track_pos};
      if (cmd == CMD_MOVE) begin
         if (raw == '0) begin
            track_pending = '0;
         end else if (raw[CNT_W-1]) begin
            track_fwd = 1'b0;
            track_pending = ~raw + 1'b1;
         end else begin
            track_fwd = 1'b1;
            track_pending = raw;
         end
      end else begin
         if (track_elapsed != {CNT_W{1'b1}}) track_elapsed = track_elapsed + 1'b1;
         if (track_pending != '0 && track_elapsed >= cfg_delay) begin
            track_elapsed = '0;
            if (track_fwd) begin
               pos = (pos + 1'b1 >= rev) ? '0 : pos + 1'b1;
            end else begin
               pos = (pos == '0 || pos >= rev) ? rev - 1'b1 : pos - 1'b1;
            end
            track_pos = pos[CNT_W-1:0];
            track_pending = track_pending - 1'b1;
            track_coils = PHASE_COILS[track_pos[2:0]];
            moved = 1'b1;
         end
      end
      r.coils = track_coils;
      r.position = track_pos;
      r.steps_remaining = track_pending;
      r.stepped = moved;
      r.busy_res = (track_pending != '0);
      return r;
   endfunction

   function automatic rsp_type result_of(input int c, input int p, input int s, input int st,
                                         input int b);
      rsp_type r;
      r.coils = COIL_W'(c);
      r.position = CNT_W'(p);
      r.steps_remaining = CNT_W'(s);
      r.stepped = st[0];
      r.busy_res = b[0];
      return r;
   endfunction

   function automatic plan_row free_row(input cmd_type cmd, input int steps);
      plan_row r;
      r = '0;
      r.kind = ROW_ITEM;
      r.cmd = cmd;
      r.steps = CNT_W'(steps);
      return r;
   endfunction

   function automatic plan_row fixed_row(input cmd_type cmd, input int steps, input rsp_type want);
      plan_row r;
      r = free_row(cmd, steps);
      r.kind = ROW_PINNED;
      r.want = want;
      return r;
   endfunction

   function automatic plan_row csr_row(input logic [CSR_IDX_W-1:0] idx, input int data);
      plan_row r;
      r = '0;
      r.kind = ROW_CSR;
      r.idx = idx;
      r.data = CSR_DAT_W'(data);
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                       input logic [CNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      bit      fired;
      rsp_type want;
      rsp_type got;
      fired = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            fired = 1'b1;
            if (pending_results.size() == 0) begin
               $error("result item with no expectation waiting");
               failures++;
            end else begin
               want = pending_results.pop_front();
               check_field("coils", CNT_W'(want.coils), CNT_W'(rsp_coils));
               check_field("position", want.position, rsp_position);
               check_field("steps_remaining", want.steps_remaining, rsp_steps_remaining);
               check_field("stepped", CNT_W'(want.stepped), CNT_W'(rsp_stepped));
               check_field("busy_res", CNT_W'(want.busy_res), CNT_W'(rsp_busy_res));
            end
         end
         if (req_valid && req_ready) begin
            fired = 1'b1;
            got = stepper_next(req_cmd, req_move_steps);
            pending_results.push_back(pin_on ? pin_want : got);
         end
         if (csr_valid && csr_ready) begin
            fired = 1'b1;
            if (csr_index == CSR_STEPS_PER_REV) cfg_rev = csr_data;
            else if (csr_index == CSR_STEP_DELAY) cfg_delay = csr_data;
         end
         quiet_cycles = fired ? 0 : quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      while (quiet_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : rsp_side
      int unsigned hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold != 0 && !calm) begin
            rsp_ready = 1'b0;
            hold--;
         end else begin
            rsp_ready = 1'b1;
            hold = pick_gap();
         end
      end
   end

   // enter and leave at a falling edge
   task automatic send_item(input cmd_type cmd, input logic [CNT_W-1:0] steps, input bit pin,
                            input rsp_type want);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      pin_on = pin;
      pin_want = want;
      req_cmd = cmd;
      req_move_steps = steps;
      req_valid = 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid = 1'b0;
      pin_on = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_index = idx;
      csr_data = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_item(output cmd_type cmd, output logic [CNT_W-1:0] steps);
      int unsigned r;
      int          n;
      r = $urandom_range(0, 99);
      n = $urandom_range(1, 20);
      cmd = CMD_MOVE;
      steps = CNT_W'($urandom);
      if (r < 72) begin
         cmd = CMD_TICK;
      end else if (r < 88) begin
         steps = CNT_W'($urandom_range(0, 1) ? n : -n);
      end else if (r < 92) begin
         steps = '0;
      end else if (r < 96) begin
         case ($urandom_range(0, 3))
            0: steps = 16'h8000;
            1: steps = 16'h7FFF;
            2: steps = 16'h0001;
            default: steps = 16'hFFFF;
         endcase
      end
   endtask

   initial begin : stimulus
      cmd_type          cmd;
      logic [CNT_W-1:0] steps;
      logic [CNT_W-1:0] rev_val;
      logic [CNT_W-1:0] delay_val;

      plan.push_back(fixed_row(CMD_TICK, 0, result_of(0, 0, 0, 0, 0)));
      plan.push_back(fixed_row(CMD_MOVE, 0, result_of(0, 0, 0, 0, 0)));
      plan.push_back(fixed_row(CMD_MOVE, -32768, result_of(0, 0, 32768, 0, 1)));
      plan.push_back(fixed_row(CMD_TICK, 0, result_of(9, 4095, 32767, 1, 1)));
      plan.push_back(fixed_row(CMD_TICK, 0, result_of(8, 4094, 32766, 1, 1)));
      plan.push_back(fixed_row(CMD_MOVE, 0, result_of(8, 4094, 0, 0, 0)));
      plan.push_back(fixed_row(CMD_TICK, -1, result_of(8, 4094, 0, 0, 0)));
      plan.push_back(csr_row(CSR_STEPS_PER_REV, 10));
      plan.push_back(fixed_row(CMD_MOVE, -1, result_of(8, 4094, 1, 0, 1)));
      plan.push_back(fixed_row(CMD_TICK, 0, result_of(3, 9, 0, 1, 0)));
      plan.push_back(csr_row(CSR_STEPS_PER_REV, 5));
      plan.push_back(fixed_row(CMD_MOVE, 1, result_of(3, 9, 1, 0, 1)));
      plan.push_back(fixed_row(CMD_TICK, 0, result_of(1, 0, 0, 1, 0)));
      plan.push_back(csr_row(CSR_STEPS_PER_REV, 0));
      plan.push_back(free_row(CMD_MOVE, -2));
      plan.push_back(fixed_row(CMD_TICK, 0, result_of(9, 65535, 1, 1, 1)));
      plan.push_back(free_row(CMD_TICK, 32767));
      plan.push_back(csr_row(CSR_SPARE, 65535));
      plan.push_back(csr_row(CSR_STEP_DELAY, 65535));
      plan.push_back(free_row(CMD_MOVE, 32767));
      plan.push_back(free_row(CMD_TICK, 0));
      plan.push_back(csr_row(CSR_STEP_DELAY, 1));
      plan.push_back(free_row(CMD_TICK, 0));
      plan.push_back(free_row(CMD_TICK, 0));
      plan.push_back(csr_row(CSR_STEP_DELAY, 3));
      plan.push_back(free_row(CMD_MOVE, -4));
      plan.push_back(free_row(CMD_TICK, 0));
      plan.push_back(free_row(CMD_TICK, 0));
      plan.push_back(free_row(CMD_TICK, 0));
      plan.push_back(free_row(CMD_TICK, 0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            write_csr(plan[i].idx, plan[i].data);
         end else begin
            send_item(plan[i].cmd, plan[i].steps, plan[i].kind == ROW_PINNED, plan[i].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin rev_val = CNT_W'(4096); delay_val = CNT_W'(0); end
            1: begin rev_val = CNT_W'(1); delay_val = CNT_W'(1); end
            2: begin rev_val = CNT_W'(2); delay_val = CNT_W'(0); end
            3: begin rev_val = CNT_W'(8); delay_val = CNT_W'(2); end
            4: begin rev_val = CNT_W'(0); delay_val = CNT_W'(3); end
            5: begin rev_val = CNT_W'(65535); delay_val = CNT_W'(0); end
            6: begin rev_val = CNT_W'(3); delay_val = CNT_W'(65535); end
            7: begin
               rev_val = CNT_W'($urandom_range(1, 65535));
               delay_val = CNT_W'($urandom_range(0, 7));
            end
            8: begin rev_val = CNT_W'(9); delay_val = CNT_W'(1); end
            default: begin rev_val = CNT_W'(16); delay_val = CNT_W'($urandom_range(0, 5)); end
         endcase
         settle();
         write_csr(CSR_STEPS_PER_REV, rev_val);
         write_csr(CSR_STEP_DELAY, delay_val);
         if ($urandom_range(0, 2) == 0)
            write_csr(CSR_IDX_W'($urandom_range(CSR_SPARE, CSR_LAST)), CSR_DAT_W'($urandom));
         calm = (ph == 2) || ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_LEN; n++) begin
            if ($urandom_range(0, 99) == 0) settle();
            random_item(cmd, steps);
            send_item(cmd, steps, 1'b0, '0);
         end
      end

      // let the tick count run up while idle, then a move steps on its first tick
      settle();
      write_csr(CSR_STEPS_PER_REV, CSR_DAT_W'(4096));
      write_csr(CSR_STEP_DELAY, CSR_DAT_W'(IDLE_TICKS));
      calm = 1'b1;
      send_item(CMD_MOVE, '0, 1'b0, '0);
      repeat (IDLE_TICKS) send_item(CMD_TICK, CNT_W'($urandom), 1'b0, '0);
      send_item(CMD_MOVE, 16'h0001, 1'b0, '0);
      send_item(CMD_TICK, '0, 1'b0, '0);
      send_item(CMD_MOVE, 16'h0001, 1'b0, '0);
      send_item(CMD_TICK, '0, 1'b0, '0);
      calm = 1'b0;

      settle();
      repeat (8) @(negedge clock);
      if (failures == 0 && pending_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/hssq_pkg.sv
hdl/hssq_csr.sv
hdl/hssq_core.sv
hdl/hssq_rsp.sv
hdl/half_step_stepper_sequencer.sv
bench/tb.sv
